[rtl/bist_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bist_pkg
// Shared types and constants for the bounded integer set table unit.
// ----------------------------------------------------------------------------
package bist_pkg;

    localparam int VALUE_W     = 32;  // width of a member value
    localparam int OP_W        = 2;   // width of the operation code
    localparam int COUNT_W     = 5;   // width of the reported member count
    localparam int RESP_DATA_W = 8;   // response tdata, count padded to a byte

    typedef enum logic [OP_W-1:0] {
        OP_ADD      = 2'd0,
        OP_REMOVE   = 2'd1,
        OP_CONTAINS = 2'd2,
        OP_CLEAR    = 2'd3
    } op_t;

endpackage

[rtl/bist_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bist_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module bist_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/bounded_integer_set_table_unit.sv]
`timescale 1ns / 1ps
// Sequence: clear goes from acceptance straight to the response; add, remove
//   and contains scan the live members, then decide (a remove hit adds a move).
// Requests: one at a time; the next is taken the cycle after the response is
//   registered, and a search is bounded by the number of live members.
// Search time is set by the member RAM scan: one entry read per cycle.
// Reset: asynchronous, active low; set empties, no stale response pending.
// ----------------------------------------------------------------------------
// bounded_integer_set_table_unit
// Set of distinct 32-bit integers kept packed in a RAM, with add, remove,
// membership query and clear requests; one response per request.
// ----------------------------------------------------------------------------
module bounded_integer_set_table_unit
    import bist_pkg::*;
#(
    parameter int SET_SIZE = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,

    // Request channel
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [VALUE_W-1:0]     s_tdata,   // [31:0] value
    input  logic [OP_W-1:0]        s_tuser,   // [1:0] operation

    // Response channel
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [RESP_DATA_W-1:0] m_tdata,   // [4:0] count, [7:5] zero
    output logic                   m_tuser    // [0] ok
);

    // Address covers the table; the count must also hold SET_SIZE itself.
    localparam int AW = (SET_SIZE > 1) ? $clog2(SET_SIZE) : 1;
    localparam int CW = $clog2(SET_SIZE + 1);

    // One-hot sequencer.
    //   IDLE : take a request
    //   SCAN : compare one RAM entry per cycle against the value
    //   ACT  : decide; add writes here, remove fetches the last live entry
    //   MOVE : remove writes the last entry into the hole
    //   DONE : load the response register once it is free
    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_SCAN = 5'b00010,
        ST_ACT  = 5'b00100,
        ST_MOVE = 5'b01000,
        ST_DONE = 5'b10000
    } state_t;

    state_t              state_reg,   state_next;
    logic [CW-1:0]       count_reg,   count_next;
    op_t                 op_reg,      op_next;
    logic [VALUE_W-1:0]  value_reg,   value_next;
    logic [AW-1:0]       idx_reg,     idx_next;    // entry on mem_rdata / hit slot
    logic                hit_reg,     hit_next;
    logic                ok_reg,      ok_next;
    logic                m_valid_reg, m_valid_next;
    logic                m_ok_reg,    m_ok_next;
    logic [COUNT_W-1:0]  m_count_reg, m_count_next;

    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [VALUE_W-1:0]  mem_wdata;
    logic [AW-1:0]       mem_raddr;
    logic [VALUE_W-1:0]  mem_rdata;

    logic [CW-1:0]       last_idx;
    logic                s_accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign last_idx = count_reg - CW'(1);

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_ok_reg;
    assign m_tdata  = RESP_DATA_W'(m_count_reg);

    // Member storage. Requests are serialized and every write lands before the
    // next request's first read, so no forwarding is needed between the write
    // and read ports.
    bist_ram #(
        .WIDTH  (VALUE_W),
        .DEPTH  (SET_SIZE),
        .ADDR_W (AW)
    ) u_members (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        op_next      = op_reg;
        value_next   = value_reg;
        idx_next     = idx_reg;
        hit_next     = hit_reg;
        ok_next      = ok_reg;
        m_ok_next    = m_ok_reg;
        m_count_next = m_count_reg;
        m_valid_next = m_valid_reg && !m_tready;

        mem_we    = 1'b0;
        mem_waddr = idx_reg;
        mem_wdata = value_reg;
        mem_raddr = idx_reg;

        case (state_reg)
            ST_IDLE:
            begin
                // Entry 0 is read speculatively so the scan starts next cycle.
                mem_raddr = '0;
                if (s_accept)
                begin
                    op_next    = op_t'(s_tuser);
                    value_next = s_tdata;
                    idx_next   = '0;
                    hit_next   = 1'b0;
                    if (op_t'(s_tuser) == OP_CLEAR)
                    begin
                        // Stored entries stay; they are simply no longer live.
                        count_next = '0;
                        ok_next    = 1'b1;
                        state_next = ST_DONE;
                    end
                    else if (count_reg == '0)
                    begin
                        state_next = ST_ACT;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                // Fetch the following entry while comparing this one.
                mem_raddr = idx_reg + AW'(1);
                if (mem_rdata == value_reg)
                begin
                    hit_next   = 1'b1;
                    state_next = ST_ACT;
                end
                else if (CW'(idx_reg) == last_idx)
                begin
                    state_next = ST_ACT;
                end
                else
                begin
                    idx_next = idx_reg + AW'(1);
                end
            end

            ST_ACT:
            begin
                mem_raddr  = AW'(last_idx);
                state_next = ST_DONE;
                case (op_reg)
                    OP_ADD:
                    begin
                        if (!hit_reg && (count_reg < CW'(SET_SIZE)))
                        begin
                            mem_we     = 1'b1;
                            mem_waddr  = AW'(count_reg);
                            mem_wdata  = value_reg;
                            count_next = count_reg + CW'(1);
                            ok_next    = 1'b1;
                        end
                        else
                        begin
                            ok_next = 1'b0;
                        end
                    end
                    OP_REMOVE:
                    begin
                        if (hit_reg)
                        begin
                            state_next = ST_MOVE;
                        end
                        else
                        begin
                            ok_next = 1'b0;
                        end
                    end
                    OP_CONTAINS:
                    begin
                        ok_next = hit_reg;
                    end
                    default:
                    begin
                        ok_next = 1'b1;
                    end
                endcase
            end

            ST_MOVE:
            begin
                // Last live entry fills the hole; the tail slot goes dead.
                mem_we     = 1'b1;
                mem_waddr  = idx_reg;
                mem_wdata  = mem_rdata;
                count_next = last_idx;
                ok_next    = 1'b1;
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_ok_next    = ok_reg;
                    m_count_next = COUNT_W'(count_reg);
                    state_next   = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        value_reg   <= value_next;
        idx_reg     <= idx_next;
        hit_reg     <= hit_next;
        ok_reg      <= ok_next;
        m_ok_reg    <= m_ok_next;
        m_count_reg <= m_count_next;
    end

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(SET_SIZE))
        else $error("member count exceeds table size");

    a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == ST_ACT || state_reg == ST_MOVE))
        else $error("member write outside act/move");

    a_add_room: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && state_reg == ST_ACT) |-> (count_reg < CW'(SET_SIZE)))
        else $error("add wrote into a full table");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (s_accept && s_tuser == OP_CLEAR) |=> (count_reg == '0))
        else $error("clear did not empty the set");

    a_move_on_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MOVE) |-> (hit_reg && op_reg == OP_REMOVE && count_reg != '0))
        else $error("move without a remove hit");

endmodule
